// ===== hdl/wmse_pkg.sv =====
package wmse_pkg;

	localparam logic [1:0] MODE_NONE    = 2'd0;
	localparam logic [1:0] MODE_SUM     = 2'd1;
	localparam logic [1:0] MODE_MEAN    = 2'd2;
	localparam logic [1:0] MODE_NONZERO = 2'd3;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;

	localparam int DIV_STEPS = 72;
	localparam int DIV_CW    = 7;

	typedef struct packed {
		logic               div;
		logic               shift8;
		logic               reduced;
		logic signed [63:0] num;
		logic signed [39:0] den;
	} wmse_job_t;

	typedef struct packed {
		logic busy;
		logic done;
	} wmse_div_status_t;

endpackage

// ===== hdl/wmse_front.sv =====
module wmse_front import wmse_pkg::*; #(
	parameter int MAX_ELEMENTS = 1048576,
	parameter int CNT_W        = 21
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         mode,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] prediction,
	input  logic signed [15:0] label,
	input  logic signed [15:0] weight,
	input  logic               last_element,
	input  logic               q_full,
	output logic               q_push,
	output wmse_job_t          q_job
);

	logic               v_s1_q, v_s2_q, v_s3_q;
	logic signed [16:0] d_s1_q;
	logic signed [15:0] w_s1_q, w_s2_q, w_s3_q;
	logic               last_s1_q, last_s2_q, last_s3_q;
	logic [31:0]        dd_s2_q;
	logic signed [40:0] werr_s3_q;

	logic signed [63:0] err_sum_q;
	logic signed [39:0] wgt_sum_q;
	logic [CNT_W-1:0]   nz_cnt_q;

	logic signed [33:0] sq;
	logic signed [48:0] prod;
	logic signed [64:0] err_add;
	logic signed [40:0] wgt_add;
	logic signed [63:0] err_new;
	logic signed [39:0] wgt_new;
	logic [CNT_W-1:0]   cnt_new;
	logic               need_push;
	logic               en;

	assign sq   = d_s1_q * d_s1_q;
	assign prod = $signed({1'b0, dd_s2_q}) * w_s2_q;

	assign err_add = {err_sum_q[63], err_sum_q} + {{24{werr_s3_q[40]}}, werr_s3_q};
	assign wgt_add = {wgt_sum_q[39], wgt_sum_q} + {{25{w_s3_q[15]}}, w_s3_q};

	always_comb begin
		if (err_add[64] != err_add[63]) begin
			err_new = err_add[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end else begin
			err_new = err_add[63:0];
		end
		if (wgt_add[40] != wgt_add[39]) begin
			wgt_new = wgt_add[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
		end else begin
			wgt_new = wgt_add[39:0];
		end
		if (w_s3_q != 16'sd0 && nz_cnt_q < CNT_W'(MAX_ELEMENTS)) begin
			cnt_new = nz_cnt_q + CNT_W'(1);
		end else begin
			cnt_new = nz_cnt_q;
		end
	end

	always_comb begin
		q_job.div     = 1'b0;
		q_job.shift8  = 1'b0;
		q_job.reduced = 1'b1;
		q_job.num     = err_new;
		q_job.den     = wgt_new;
		case (mode)
			MODE_NONE: begin
				q_job.reduced = 1'b0;
				q_job.num     = {{23{werr_s3_q[40]}}, werr_s3_q};
			end
			MODE_SUM: begin
			end
			MODE_MEAN: begin
				q_job.div    = 1'b1;
				q_job.shift8 = 1'b1;
			end
			default: begin
				q_job.div = 1'b1;
				q_job.den = $signed({{(40 - CNT_W){1'b0}}, cnt_new});
			end
		endcase
	end

	assign need_push = (mode == MODE_NONE) || last_s3_q;
	assign en        = !(v_s3_q && need_push && q_full);
	assign in_ready  = en;
	assign q_push    = v_s3_q && need_push && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q    <= 1'b0;
			v_s2_q    <= 1'b0;
			v_s3_q    <= 1'b0;
			err_sum_q <= '0;
			wgt_sum_q <= '0;
			nz_cnt_q  <= '0;
		end else if (en) begin
			v_s1_q <= in_valid;
			v_s2_q <= v_s1_q;
			v_s3_q <= v_s2_q;
			if (v_s3_q) begin
				if (last_s3_q) begin
					err_sum_q <= '0;
					wgt_sum_q <= '0;
					nz_cnt_q  <= '0;
				end else begin
					err_sum_q <= err_new;
					wgt_sum_q <= wgt_new;
					nz_cnt_q  <= cnt_new;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1_q    <= {prediction[15], prediction} - {label[15], label};
			w_s1_q    <= weight;
			last_s1_q <= last_element;
			dd_s2_q   <= sq[31:0];
			w_s2_q    <= w_s1_q;
			last_s2_q <= last_s1_q;
			werr_s3_q <= prod[48:8];
			w_s3_q    <= w_s2_q;
			last_s3_q <= last_s2_q;
		end
	end

endmodule

// ===== hdl/wmse_fifo.sv =====
module wmse_fifo import wmse_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  wmse_job_t push_job,
	input  logic      pop,
	output wmse_job_t head,
	output logic      empty,
	output logic      full
);

	wmse_job_t           mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_AW:0]   cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == (QUEUE_AW + 1)'(QUEUE_DEPTH));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (QUEUE_AW + 1)'(1);
				2'b01:   cnt_q <= cnt_q - (QUEUE_AW + 1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("Transaction pushed into a full queue.");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("Queue popped while empty.");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QUEUE_AW + 1)'(QUEUE_DEPTH))
		else $error("Queue count exceeds its depth.");

endmodule

// ===== hdl/wmse_div.sv =====
module wmse_div import wmse_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  wmse_job_t          job,
	input  logic               ack,
	output wmse_div_status_t   status,
	output logic signed [63:0] result
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]        state_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [71:0]       quo_q;
	logic [39:0]       rem_q;
	logic [39:0]       ud_q;
	logic              neg_q;

	logic [63:0] un;
	logic [39:0] ud;
	logic [40:0] trial;
	logic        fits;

	assign un    = job.num[63] ? (64'd0 - job.num) : job.num;
	assign ud    = job.den[39] ? (40'd0 - job.den) : job.den;
	assign trial = {rem_q, quo_q[71]};
	assign fits  = trial >= {1'b0, ud_q};

	assign status.busy = (state_q == ST_RUN);
	assign status.done = (state_q == ST_DONE);

	always_comb begin
		if (neg_q) begin
			if (|quo_q[71:64] || (quo_q[63] && |quo_q[62:0])) begin
				result = {1'b1, 63'd0};
			end else begin
				result = 64'sd0 - $signed(quo_q[63:0]);
			end
		end else begin
			if (|quo_q[71:63]) begin
				result = {1'b0, {63{1'b1}}};
			end else begin
				result = $signed(quo_q[63:0]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						cnt_q   <= '0;
						state_q <= (job.den == 40'sd0) ? ST_DONE : ST_RUN;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + DIV_CW'(1);
					if (cnt_q == DIV_CW'(DIV_STEPS - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (ack) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			rem_q <= '0;
			ud_q  <= ud;
			if (job.den == 40'sd0) begin
				quo_q <= '0;
				neg_q <= 1'b0;
			end else begin
				quo_q <= job.shift8 ? {un, 8'd0} : {8'd0, un};
				neg_q <= job.num[63] != job.den[39];
			end
		end else if (state_q == ST_RUN) begin
			rem_q <= fits ? 40'(trial - {1'b0, ud_q}) : trial[39:0];
			quo_q <= {quo_q[70:0], fits};
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == ST_IDLE)
		else $error("Division started while the divider was occupied.");

endmodule

// ===== hdl/wmse_back.sv =====
module wmse_back import wmse_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  wmse_job_t   head,
	input  logic        q_empty,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] out_data,
	output logic        out_user
);

	wmse_div_status_t   div_status;
	logic signed [63:0] div_result;
	logic               div_start;
	logic               div_ack;
	logic               pend_q;
	logic               out_valid_q;
	logic [63:0]        out_data_q;
	logic               out_user_q;
	logic               can_load;
	logic               load_direct;

	assign can_load    = !out_valid_q || out_ready;
	assign q_pop       = !q_empty && !pend_q && (head.div || can_load);
	assign div_start   = q_pop && head.div;
	assign load_direct = q_pop && !head.div;
	assign div_ack     = div_status.done && can_load;

	wmse_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.job    (head),
		.ack    (div_ack),
		.status (div_status),
		.result (div_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (div_start) begin
				pend_q <= 1'b1;
			end else if (div_ack) begin
				pend_q <= 1'b0;
			end
			if (load_direct || div_ack) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_direct) begin
			out_data_q <= head.num;
			out_user_q <= head.reduced;
		end else if (div_ack) begin
			out_data_q <= div_result;
			out_user_q <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_user  = out_user_q;

	a_div_tracked: assert property (@(posedge clk) disable iff (!arst_n)
		(div_status.busy || div_status.done) |-> pend_q)
		else $error("Divider active without a pending transaction.");

endmodule

// ===== hdl/weighted_mse_loss_reduce.sv =====
// Channel     Direction  Handshake                      Payload
// s_axis      in         s_axis_tvalid / s_axis_tready  prediction, label, weight; tlast
// m_axis      out        m_axis_tvalid / m_axis_tready  loss_value; tuser is_reduced
// cfg         in         cfg_wr_en                      reduction_mode
//
// One input transaction is taken per cycle unless input stalls. A three-stage multiply
// and accumulate pipeline feeds the queue from its last stage.
// A weighted mean or nonzero-count reduction then runs a restoring divider at one quotient
// bit per cycle; when the divisor is zero it skips the run and gives a result of zero.
// The four-entry queue lets input flow while the divider works; input stalls when a push
// meets a full queue. Reset clears the accumulators and sets the mode to weighted sum.
module weighted_mse_loss_reduce import wmse_pkg::*; #(
	parameter int MAX_ELEMENTS = 1048576
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_wr_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // prediction [15:0], label [31:16], weight [47:32]
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // loss_value [63:0]
	output logic        m_axis_tuser   // is_reduced [0]
);

	localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

	logic [1:0] mode_q;
	logic       q_push, q_pop, q_empty, q_full;
	wmse_job_t  push_job, head_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SUM;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	wmse_front #(
		.MAX_ELEMENTS (MAX_ELEMENTS),
		.CNT_W        (CNT_W)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.mode         (mode_q),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.prediction   (s_axis_tdata[15:0]),
		.label        (s_axis_tdata[31:16]),
		.weight       (s_axis_tdata[47:32]),
		.last_element (s_axis_tlast),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_job        (push_job)
	);

	wmse_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.pop      (q_pop),
		.head     (head_job),
		.empty    (q_empty),
		.full     (q_full)
	);

	wmse_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head_job),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser)
	);

endmodule
